/* sv/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants for the stepped pulse train
// Field widths, register indexes, reset values and the structs passed
// between the register file, the sequencer core and the top level.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int TICK_W  = 24;   // tick count registers
	localparam int CNT_W   = 8;    // pulse_count
	localparam int LVL_W   = 16;   // offset / amplitude registers
	localparam int CUR_W   = 17;   // commanded current
	localparam int PN_W    = 9;    // pulse number
	localparam int ELAP_W  = 32;   // elapsed tick counter
	localparam int SUM_W   = 25;   // sum of two tick counts
	localparam int BND_W   = 35;   // absolute tick bounds
	localparam int IDX_W   = 3;    // register index
	localparam int DATA_W  = 24;   // write data, widest register

	localparam logic [IDX_W-1:0] REG_DELAY     = 3'd0;
	localparam logic [IDX_W-1:0] REG_PULSE     = 3'd1;
	localparam logic [IDX_W-1:0] REG_PAUSE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_COUNT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_HYPER_GAP = 3'd4;
	localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd5;
	localparam logic [IDX_W-1:0] REG_STEP      = 3'd6;
	localparam logic [IDX_W-1:0] REG_HYPER_AMP = 3'd7;

	localparam int RST_DELAY     = 100000;
	localparam int RST_PULSE     = 10000;
	localparam int RST_PAUSE     = 100000;
	localparam int RST_COUNT     = 15;
	localparam int RST_HYPER_GAP = 500;
	localparam int RST_OFFSET    = 0;
	localparam int RST_STEP      = 50;
	localparam int RST_HYPER_AMP = 40;

	localparam int DEF_HYPER_PULSES   = 5;
	localparam int DEF_HYPER_ON_TICKS = 50;

	typedef struct packed {
		logic [TICK_W-1:0]        delay_ticks;
		logic [TICK_W-1:0]        pulse_ticks;
		logic [TICK_W-1:0]        pause_ticks;
		logic [CNT_W-1:0]         pulse_count;
		logic [TICK_W-1:0]        hyper_gap_ticks;
		logic signed [LVL_W-1:0]  offset_level;
		logic signed [LVL_W-1:0]  step_amplitude;
		logic signed [LVL_W-1:0]  hyper_amplitude;
	} cfg_t;

	// sums derived from the registers, kept in flops
	typedef struct packed {
		logic [SUM_W-1:0] per;        // pulse + pause
		logic [SUM_W-1:0] hyp;        // hyper gap + hyper on time
		logic [BND_W-1:0] rst_pend;   // bounds of the first period
		logic [BND_W-1:0] rst_nend;
		logic [BND_W-1:0] rst_hend;
	} der_t;

	typedef struct packed {
		logic signed [CUR_W-1:0] current_pa;
		logic [PN_W-1:0]         pulse_number;
		logic                    finished;
	} res_t;

endpackage

/* sv/spt_cfg.sv */
// ----------------------------------------------------------------------------
// spt_cfg: configuration registers
// Holds the eight timing and level registers and the sums derived from them.
// ----------------------------------------------------------------------------
module spt_cfg #(
	parameter int HYPER_ON_TICKS = spt_pkg::DEF_HYPER_ON_TICKS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [spt_pkg::IDX_W-1:0] wr_index,
	input  logic [spt_pkg::DATA_W-1:0] wr_data,
	output spt_pkg::cfg_t             cfg,
	output spt_pkg::der_t             der
);
	import spt_pkg::*;

	localparam logic [SUM_W-1:0] ON_S = SUM_W'(HYPER_ON_TICKS);

	cfg_t cfg_q;
	der_t der_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks     <= TICK_W'(RST_DELAY);
			cfg_q.pulse_ticks     <= TICK_W'(RST_PULSE);
			cfg_q.pause_ticks     <= TICK_W'(RST_PAUSE);
			cfg_q.pulse_count     <= CNT_W'(RST_COUNT);
			cfg_q.hyper_gap_ticks <= TICK_W'(RST_HYPER_GAP);
			cfg_q.offset_level    <= LVL_W'(RST_OFFSET);
			cfg_q.step_amplitude  <= LVL_W'(RST_STEP);
			cfg_q.hyper_amplitude <= LVL_W'(RST_HYPER_AMP);
		end else if (wr_en) begin
			case (wr_index)
				REG_DELAY:     cfg_q.delay_ticks     <= wr_data;
				REG_PULSE:     cfg_q.pulse_ticks     <= wr_data;
				REG_PAUSE:     cfg_q.pause_ticks     <= wr_data;
				REG_COUNT:     cfg_q.pulse_count     <= wr_data[CNT_W-1:0];
				REG_HYPER_GAP: cfg_q.hyper_gap_ticks <= wr_data;
				REG_OFFSET:    cfg_q.offset_level    <= wr_data[LVL_W-1:0];
				REG_STEP:      cfg_q.step_amplitude  <= wr_data[LVL_W-1:0];
				REG_HYPER_AMP: cfg_q.hyper_amplitude <= wr_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			der_q.per      <= SUM_W'(RST_PULSE + RST_PAUSE);
			der_q.hyp      <= SUM_W'(RST_HYPER_GAP + HYPER_ON_TICKS);
			der_q.rst_pend <= BND_W'(RST_DELAY + RST_PULSE);
			der_q.rst_nend <= BND_W'(RST_DELAY + RST_PULSE + RST_PAUSE);
			der_q.rst_hend <= BND_W'(RST_DELAY + RST_HYPER_GAP + HYPER_ON_TICKS);
		end else begin
			der_q.per      <= SUM_W'(cfg_q.pulse_ticks) + SUM_W'(cfg_q.pause_ticks);
			der_q.hyp      <= SUM_W'(cfg_q.hyper_gap_ticks) + ON_S;
			der_q.rst_pend <= BND_W'(cfg_q.delay_ticks) + BND_W'(cfg_q.pulse_ticks);
			der_q.rst_nend <= BND_W'(cfg_q.delay_ticks) + BND_W'(cfg_q.pulse_ticks)
				+ BND_W'(cfg_q.pause_ticks);
			der_q.rst_hend <= BND_W'(cfg_q.delay_ticks) + BND_W'(cfg_q.hyper_gap_ticks)
				+ BND_W'(ON_S);
		end
	end

	assign cfg = cfg_q;
	assign der = der_q;

endmodule

/* sv/spt_core.sv */
// ----------------------------------------------------------------------------
// spt_core: sequencer state and per-tick level decision
// Keeps elapsed time, period and short-pulse counters and the absolute tick
// bounds of the current period; rebuilds the bounds after a register write.
// ----------------------------------------------------------------------------
module spt_core #(
	parameter int HYPER_PULSES   = spt_pkg::DEF_HYPER_PULSES,
	parameter int HYPER_ON_TICKS = spt_pkg::DEF_HYPER_ON_TICKS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spt_pkg::cfg_t cfg,
	input  spt_pkg::der_t der,
	input  logic          wr_en,
	input  logic          adv,
	input  logic          restart,
	output spt_pkg::res_t res_next,
	output logic          busy
);
	import spt_pkg::*;

	localparam int HIW = $clog2(HYPER_PULSES + 2);
	localparam logic [HIW-1:0]   HI_MAX = HIW'(HYPER_PULSES);
	localparam logic [HIW-1:0]   HI_ONE = HIW'(1);
	localparam logic [PN_W-1:0]  PN_ONE = PN_W'(1);
	localparam logic [BND_W-1:0] ON_B   = BND_W'(HYPER_ON_TICKS);

	// bound rebuild sequence
	localparam logic [2:0] RC_IDLE   = 3'd0;
	localparam logic [2:0] RC_SETTLE = 3'd1;
	localparam logic [2:0] RC_MUL    = 3'd2;
	localparam logic [2:0] RC_START  = 3'd3;
	localparam logic [2:0] RC_BOUND  = 3'd4;

	logic [2:0]              rc_q;
	logic [ELAP_W-1:0]       elapsed_q;
	logic [PN_W-1:0]         pi_q;
	logic [HIW-1:0]          hi_q;
	logic signed [CUR_W-1:0] last_q;
	logic [BND_W-1:0]        pend_q, nend_q, hend_q;
	logic [BND_W-1:0]        prod_p_q, prod_h_q, start_q;

	logic [PN_W-1:0]           pm1;
	logic [CNT_W+SUM_W-1:0]    prod_p_w;
	logic [HIW+SUM_W-1:0]      prod_h_w;

	logic [ELAP_W-1:0]       t;
	logic [BND_W-1:0]        t_b;
	logic [PN_W-1:0]         pi_e, pi_inc, pc;
	logic [HIW-1:0]          hi_e;
	logic [BND_W-1:0]        pend_e, nend_e, hend_e;
	logic                    active, in_pulse, hyp_ok, hyp_on, hyp_adv, per_end;
	logic signed [CUR_W-1:0] lo, ls, lh;

	logic [ELAP_W-1:0]       el_n;
	logic [PN_W-1:0]         pi_n;
	logic [HIW-1:0]          hi_n;
	logic [BND_W-1:0]        pend_n, nend_n, hend_n;
	logic signed [CUR_W-1:0] lvl_n;

	assign busy = (rc_q != RC_IDLE);

	// restart takes effect before the tick is evaluated
	assign t      = restart ? '0 : elapsed_q;
	assign t_b    = {{(BND_W-ELAP_W){1'b0}}, t};
	assign pi_e   = restart ? PN_ONE : pi_q;
	assign hi_e   = restart ? HI_ONE : hi_q;
	assign pend_e = restart ? der.rst_pend : pend_q;
	assign nend_e = restart ? der.rst_nend : nend_q;
	assign hend_e = restart ? der.rst_hend : hend_q;
	assign pc     = {1'b0, cfg.pulse_count};
	assign pi_inc = pi_e + PN_ONE;

	assign lo = {cfg.offset_level[LVL_W-1], cfg.offset_level};
	assign ls = lo + {cfg.step_amplitude[LVL_W-1], cfg.step_amplitude};
	assign lh = lo + {cfg.hyper_amplitude[LVL_W-1], cfg.hyper_amplitude};

	assign active   = (pi_e <= pc);
	assign in_pulse = (t_b >= BND_W'(cfg.delay_ticks)) && (t_b < pend_e);
	assign hyp_ok   = (hi_e <= HI_MAX);
	assign hyp_on   = ((t_b + ON_B) >= hend_e);
	assign hyp_adv  = (t_b >= hend_e);
	assign per_end  = (t_b >= nend_e);

	always_comb begin
		if (restart)
			el_n = ELAP_W'(1);
		else if (&elapsed_q)
			el_n = elapsed_q;
		else
			el_n = elapsed_q + ELAP_W'(1);

		pi_n   = pi_e;
		hi_n   = hi_e;
		pend_n = pend_e;
		nend_n = nend_e;
		hend_n = hend_e;
		lvl_n  = last_q;

		if (active) begin
			if (in_pulse) begin
				lvl_n = ls;
				if (hyp_ok && hyp_on)
					lvl_n = lh;
				// short pulse holds one tick past its end, then advances
				if (hyp_ok && hyp_adv) begin
					hi_n   = hi_e + HI_ONE;
					hend_n = hend_e + BND_W'(der.hyp);
				end
			end else if (per_end) begin
				pi_n   = pi_inc;
				hi_n   = HI_ONE;
				pend_n = pend_e + BND_W'(der.per);
				nend_n = nend_e + BND_W'(der.per);
				hend_n = nend_e + BND_W'(der.hyp);
				lvl_n  = (pi_inc > pc) ? lo : ls;
			end else begin
				lvl_n = lo;
			end
		end
	end

	assign res_next.current_pa   = lvl_n;
	assign res_next.pulse_number = pi_n;
	assign res_next.finished     = (pi_n > pc);

	// bound rebuild: start = delay + (pi-1)*per, hend = start + hi*hyp
	assign pm1      = pi_q - PN_ONE;
	assign prod_p_w = pm1[CNT_W-1:0] * der.per;
	assign prod_h_w = hi_q * der.hyp;

	always_ff @(posedge clk) begin
		if (rc_q == RC_MUL) begin
			prod_p_q <= BND_W'(prod_p_w);
			prod_h_q <= BND_W'(prod_h_w);
		end
		if (rc_q == RC_START)
			start_q <= BND_W'(cfg.delay_ticks) + prod_p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q      <= RC_IDLE;
			elapsed_q <= '0;
			pi_q      <= PN_ONE;
			hi_q      <= HI_ONE;
			last_q    <= '0;
			pend_q    <= BND_W'(RST_DELAY + RST_PULSE);
			nend_q    <= BND_W'(RST_DELAY + RST_PULSE + RST_PAUSE);
			hend_q    <= BND_W'(RST_DELAY + RST_HYPER_GAP + HYPER_ON_TICKS);
		end else begin
			if (wr_en) begin
				rc_q <= RC_SETTLE;
			end else begin
				case (rc_q)
					RC_IDLE:   rc_q <= RC_IDLE;
					RC_SETTLE: rc_q <= RC_MUL;
					RC_MUL:    rc_q <= RC_START;
					RC_START:  rc_q <= RC_BOUND;
					RC_BOUND:  rc_q <= RC_IDLE;
					default:   rc_q <= RC_IDLE;
				endcase
			end

			if (rc_q == RC_BOUND) begin
				pend_q <= start_q + BND_W'(cfg.pulse_ticks);
				nend_q <= start_q + BND_W'(der.per);
				hend_q <= start_q + prod_h_q;
			end else if (adv) begin
				elapsed_q <= el_n;
				pi_q      <= pi_n;
				hi_q      <= hi_n;
				last_q    <= lvl_n;
				pend_q    <= pend_n;
				nend_q    <= nend_n;
				hend_q    <= hend_n;
			end
		end
	end

endmodule

/* sv/stepped_pulse_train_with_hyper_pulses.sv */
// ----------------------------------------------------------------------------
// stepped_pulse_train_with_hyper_pulses: stimulus current sequencer
// One input item per sample tick; one result item with the commanded current.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready, restart): one transfer per sample
//   tick. restart=1 zeroes elapsed time and sets the period and short-pulse
//   counters to one before that tick is evaluated.
//   Output channel (result_valid/result_ready): current_pa, pulse_number and
//   finished for each tick, in order.
//   The input register takes the item at the transfer edge and the result
//   register takes it once the result slot is free. Throughput: one item
//   per cycle unless a bound rebuild or a stalled receiver holds the flow; the
//   decision is a few compares and adds against registered period bounds.
//   If the receiver stalls, the input register still takes one more item;
//   item_ready then drops until the result is taken.
//   Register writes (wr_en/wr_index/wr_data) are taken at once; afterwards
//   item_ready stays low while the period bounds are rebuilt from
//   the new values (one multiply stage, two add stages).
//   Reset loads the defaults, clears elapsed time, sets period and short-pulse
//   counters to one; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module stepped_pulse_train_with_hyper_pulses #(
	parameter int HYPER_PULSES   = spt_pkg::DEF_HYPER_PULSES,
	parameter int HYPER_ON_TICKS = spt_pkg::DEF_HYPER_ON_TICKS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              restart,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [spt_pkg::CUR_W-1:0]  current_pa,
	output logic [spt_pkg::PN_W-1:0]          pulse_number,
	output logic                              finished,
	input  logic                              wr_en,
	input  logic [spt_pkg::IDX_W-1:0]         wr_index,
	input  logic [spt_pkg::DATA_W-1:0]        wr_data
);
	import spt_pkg::*;

	cfg_t cfg;
	der_t der;
	res_t res_next;
	res_t res_q;
	logic busy;
	logic v_s1, restart_s1;
	logic valid_q;
	logic adv;

	spt_cfg #(
		.HYPER_ON_TICKS(HYPER_ON_TICKS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg),
		.der      (der)
	);

	spt_core #(
		.HYPER_PULSES   (HYPER_PULSES),
		.HYPER_ON_TICKS (HYPER_ON_TICKS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.der      (der),
		.wr_en    (wr_en),
		.adv      (adv),
		.restart  (restart_s1),
		.res_next (res_next),
		.busy     (busy)
	);

	// item in the input register moves on when the result slot frees up
	assign adv        = v_s1 && (!valid_q || result_ready);
	assign item_ready = !busy && (!v_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (item_ready)
				v_s1 <= item_valid;
			if (adv)
				valid_q <= 1'b1;
			else if (result_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			restart_s1 <= restart;
		if (adv)
			res_q <= res_next;
	end

	assign result_valid = valid_q;
	assign current_pa   = res_q.current_pa;
	assign pulse_number = res_q.pulse_number;
	assign finished     = res_q.finished;

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("advanced item did not reach the result register");

	a_pnum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pulse_number != '0)
		else $error("pulse number zero on a valid result");

	a_wr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !item_ready)
		else $error("input taken while period bounds are rebuilt");

endmodule
